// ===== rtl/brhp_pkg.sv =====
package brhp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_ENDIAN   = 4'd0,
        PH_VERSION  = 4'd1,
        PH_TYPE     = 4'd2,
        PH_STDERR   = 4'd3,
        PH_DRVERR   = 4'd4,
        PH_ERRLEN   = 4'd5,
        PH_ERRSTR   = 4'd6,
        PH_AFFECTED = 4'd7,
        PH_INSERT   = 4'd8,
        PH_COLCOUNT = 4'd9,
        PH_COLSTD   = 4'd10,
        PH_COLDRV   = 4'd11,
        PH_NAMELEN  = 4'd12,
        PH_NAME     = 4'd13,
        PH_IDLE     = 4'd14
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_ERRSTR   = 3'd1,
        KIND_COLUMN   = 3'd2,
        KIND_NAMEBYTE = 3'd3,
        KIND_ERROR    = 3'd4,
        KIND_DONE     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_HDR_SHORT   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_TYPE    = 3'd3,
        ST_COL_SHORT   = 3'd4,
        ST_EMPTY_NAME  = 3'd5,
        ST_NAME_SHORT  = 3'd6
    } t_status;

    typedef struct packed {
        t_kind        record_kind;
        t_status      status;
        logic [15:0]  code_first;
        logic [15:0]  code_second;
        logic [15:0]  text_length;
        logic [15:0]  count_value;
        logic [63:0]  rows_affected;
        logic [63:0]  inserted_id;
        logic [7:0]   text_byte;
        logic         final_result;
    } t_record;

    // Up to two result words per input byte, first slot fills first.
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_record rec0;
        t_record rec1;
    } t_push;

    localparam t_record REC_ZERO = '{
        record_kind:   KIND_HEADER,
        status:        ST_OK,
        code_first:    16'd0,
        code_second:   16'd0,
        text_length:   16'd0,
        count_value:   16'd0,
        rows_affected: 64'd0,
        inserted_id:   64'd0,
        text_byte:     8'd0,
        final_result:  1'b0
    };

endpackage

// ===== rtl/brhp_parser.sv =====
module brhp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_data,
    output brhp_pkg::t_push       o_push
);

    logic [31:0]       r_expected;
    brhp_pkg::t_phase  r_phase,   n_phase;
    logic [3:0]        r_cnt,     n_cnt;
    logic [63:0]       r_shift,   n_shift;
    logic [15:0]       r_std_err, n_std_err;
    logic [15:0]       r_drv_err, n_drv_err;
    logic [15:0]       r_err_len, n_err_len;
    logic [63:0]       r_affected, n_affected;
    logic [63:0]       r_insert,  n_insert;
    logic [15:0]       r_col_tot, n_col_tot;
    logic [15:0]       r_col_num, n_col_num;
    logic [15:0]       r_remain,  n_remain;
    logic [15:0]       r_col_std, n_col_std;
    logic [15:0]       r_col_drv, n_col_drv;

    logic [63:0]       asm_value;
    logic [3:0]        cnt_inc;
    logic              full2, full4, full8;

    assign asm_value = r_shift | ({56'd0, i_data_byte} << {r_cnt[2:0], 3'b000});
    assign cnt_inc   = r_cnt + 4'd1;
    assign full2     = (cnt_inc >= 4'd2);
    assign full4     = (cnt_inc >= 4'd4);
    assign full8     = (cnt_inc >= 4'd8);

    // Put a record in the first free slot.
    function automatic brhp_pkg::t_push add_rec(brhp_pkg::t_push p, brhp_pkg::t_record r);
        brhp_pkg::t_push q;
        q = p;
        if (!q.push0) begin
            q.push0 = 1'b1;
            q.rec0  = r;
        end else begin
            q.push1 = 1'b1;
            q.rec1  = r;
        end
        return q;
    endfunction

    function automatic brhp_pkg::t_record fail_rec(brhp_pkg::t_status s);
        brhp_pkg::t_record r;
        r              = brhp_pkg::REC_ZERO;
        r.record_kind  = brhp_pkg::KIND_ERROR;
        r.status       = s;
        r.final_result = 1'b1;
        return r;
    endfunction

    function automatic brhp_pkg::t_record done_rec();
        brhp_pkg::t_record r;
        r              = brhp_pkg::REC_ZERO;
        r.record_kind  = brhp_pkg::KIND_DONE;
        r.final_result = 1'b1;
        return r;
    endfunction

    always_comb begin
        brhp_pkg::t_push   p;
        brhp_pkg::t_record r;
        p          = '{push0: 1'b0, push1: 1'b0,
                       rec0: brhp_pkg::REC_ZERO, rec1: brhp_pkg::REC_ZERO};
        r          = brhp_pkg::REC_ZERO;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_shift    = r_shift;
        n_std_err  = r_std_err;
        n_drv_err  = r_drv_err;
        n_err_len  = r_err_len;
        n_affected = r_affected;
        n_insert   = r_insert;
        n_col_tot  = r_col_tot;
        n_col_num  = r_col_num;
        n_remain   = r_remain;
        n_col_std  = r_col_std;
        n_col_drv  = r_col_drv;

        case (r_phase)
            brhp_pkg::PH_ENDIAN: begin
                n_phase = brhp_pkg::PH_VERSION;
            end
            brhp_pkg::PH_VERSION: begin
                if (full4) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    if (asm_value[31:0] != r_expected) begin
                        p       = add_rec(p, fail_rec(brhp_pkg::ST_BAD_VERSION));
                        n_phase = brhp_pkg::PH_IDLE;
                    end else begin
                        n_phase = brhp_pkg::PH_TYPE;
                    end
                end else begin
                    n_shift = asm_value;
                    n_cnt   = cnt_inc;
                end
            end
            brhp_pkg::PH_TYPE: begin
                if (i_data_byte != 8'd0) begin
                    p       = add_rec(p, fail_rec(brhp_pkg::ST_BAD_TYPE));
                    n_phase = brhp_pkg::PH_IDLE;
                end else begin
                    n_phase = brhp_pkg::PH_STDERR;
                end
            end
            brhp_pkg::PH_STDERR, brhp_pkg::PH_DRVERR, brhp_pkg::PH_ERRLEN,
            brhp_pkg::PH_COLSTD, brhp_pkg::PH_COLDRV: begin
                if (full2) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    case (r_phase)
                        brhp_pkg::PH_STDERR: begin
                            n_std_err = asm_value[15:0];
                            n_phase   = brhp_pkg::PH_DRVERR;
                        end
                        brhp_pkg::PH_DRVERR: begin
                            n_drv_err = asm_value[15:0];
                            n_phase   = brhp_pkg::PH_ERRLEN;
                        end
                        brhp_pkg::PH_ERRLEN: begin
                            n_err_len = asm_value[15:0];
                            n_remain  = asm_value[15:0];
                            n_phase   = (asm_value[15:0] != 16'd0) ?
                                        brhp_pkg::PH_ERRSTR : brhp_pkg::PH_AFFECTED;
                        end
                        brhp_pkg::PH_COLSTD: begin
                            n_col_std = asm_value[15:0];
                            n_phase   = brhp_pkg::PH_COLDRV;
                        end
                        default: begin
                            n_col_drv = asm_value[15:0];
                            n_phase   = brhp_pkg::PH_NAMELEN;
                        end
                    endcase
                end else begin
                    n_shift = asm_value;
                    n_cnt   = cnt_inc;
                end
            end
            brhp_pkg::PH_ERRSTR: begin
                r             = brhp_pkg::REC_ZERO;
                r.record_kind = brhp_pkg::KIND_ERRSTR;
                r.text_length = r_err_len;
                r.text_byte   = i_data_byte;
                p             = add_rec(p, r);
                n_remain      = r_remain - 16'd1;
                if (n_remain == 16'd0) begin
                    n_phase = brhp_pkg::PH_AFFECTED;
                end
            end
            brhp_pkg::PH_AFFECTED, brhp_pkg::PH_INSERT: begin
                if (full8) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    if (r_phase == brhp_pkg::PH_AFFECTED) begin
                        n_affected = asm_value;
                        n_phase    = brhp_pkg::PH_INSERT;
                    end else begin
                        n_insert = asm_value;
                        n_phase  = brhp_pkg::PH_COLCOUNT;
                    end
                end else begin
                    n_shift = asm_value;
                    n_cnt   = cnt_inc;
                end
            end
            brhp_pkg::PH_COLCOUNT: begin
                if (full2) begin
                    n_shift         = '0;
                    n_cnt           = '0;
                    n_col_tot       = asm_value[15:0];
                    n_col_num       = 16'd0;
                    r               = brhp_pkg::REC_ZERO;
                    r.record_kind   = brhp_pkg::KIND_HEADER;
                    r.code_first    = r_std_err;
                    r.code_second   = r_drv_err;
                    r.text_length   = r_err_len;
                    r.count_value   = asm_value[15:0];
                    r.rows_affected = r_affected;
                    r.inserted_id   = r_insert;
                    p               = add_rec(p, r);
                    if (asm_value[15:0] == 16'd0) begin
                        p       = add_rec(p, done_rec());
                        n_phase = brhp_pkg::PH_IDLE;
                    end else begin
                        n_phase = brhp_pkg::PH_COLSTD;
                    end
                end else begin
                    n_shift = asm_value;
                    n_cnt   = cnt_inc;
                end
            end
            brhp_pkg::PH_NAMELEN: begin
                if (full2) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    if (asm_value[15:0] == 16'd0) begin
                        p       = add_rec(p, fail_rec(brhp_pkg::ST_EMPTY_NAME));
                        n_phase = brhp_pkg::PH_IDLE;
                    end else begin
                        n_remain      = asm_value[15:0];
                        r             = brhp_pkg::REC_ZERO;
                        r.record_kind = brhp_pkg::KIND_COLUMN;
                        r.code_first  = r_col_std;
                        r.code_second = r_col_drv;
                        r.text_length = asm_value[15:0];
                        r.count_value = r_col_num;
                        p             = add_rec(p, r);
                        n_phase       = brhp_pkg::PH_NAME;
                    end
                end else begin
                    n_shift = asm_value;
                    n_cnt   = cnt_inc;
                end
            end
            brhp_pkg::PH_NAME: begin
                r             = brhp_pkg::REC_ZERO;
                r.record_kind = brhp_pkg::KIND_NAMEBYTE;
                r.code_first  = r_col_std;
                r.code_second = r_col_drv;
                r.count_value = r_col_num;
                r.text_byte   = i_data_byte;
                p             = add_rec(p, r);
                n_remain      = r_remain - 16'd1;
                if (n_remain == 16'd0) begin
                    n_col_num = r_col_num + 16'd1;
                    if (n_col_num >= r_col_tot) begin
                        p       = add_rec(p, done_rec());
                        n_phase = brhp_pkg::PH_IDLE;
                    end else begin
                        n_phase = brhp_pkg::PH_COLSTD;
                    end
                end
            end
            default: begin
                n_phase = brhp_pkg::PH_IDLE;
            end
        endcase

        // End of buffer: flag truncation, then restart on a fresh buffer.
        if (i_last_byte) begin
            if (n_phase <= brhp_pkg::PH_COLCOUNT) begin
                p = add_rec(p, fail_rec(brhp_pkg::ST_HDR_SHORT));
            end else if (n_phase == brhp_pkg::PH_NAME) begin
                p = add_rec(p, fail_rec(brhp_pkg::ST_NAME_SHORT));
            end else if (n_phase != brhp_pkg::PH_IDLE) begin
                p = add_rec(p, fail_rec(brhp_pkg::ST_COL_SHORT));
            end
            n_phase    = brhp_pkg::PH_ENDIAN;
            n_cnt      = '0;
            n_shift    = '0;
            n_std_err  = '0;
            n_drv_err  = '0;
            n_err_len  = '0;
            n_affected = '0;
            n_insert   = '0;
            n_col_tot  = '0;
            n_col_num  = '0;
            n_remain   = '0;
            n_col_std  = '0;
            n_col_drv  = '0;
        end

        p.push0 = p.push0 & i_accept;
        p.push1 = p.push1 & i_accept;
        o_push  = p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= brhp_pkg::PH_ENDIAN;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_std_err  <= '0;
            r_drv_err  <= '0;
            r_err_len  <= '0;
            r_affected <= '0;
            r_insert   <= '0;
            r_col_tot  <= '0;
            r_col_num  <= '0;
            r_remain   <= '0;
            r_col_std  <= '0;
            r_col_drv  <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_shift    <= n_shift;
            r_std_err  <= n_std_err;
            r_drv_err  <= n_drv_err;
            r_err_len  <= n_err_len;
            r_affected <= n_affected;
            r_insert   <= n_insert;
            r_col_tot  <= n_col_tot;
            r_col_num  <= n_col_num;
            r_remain   <= n_remain;
            r_col_std  <= n_col_std;
            r_col_drv  <= n_col_drv;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_phase == brhp_pkg::PH_ENDIAN && r_cnt == 4'd0))
        else $error("parser did not restart after last byte");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push1 |-> o_push.push0)
        else $error("second slot used without first");

    a_final_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.push0 && o_push.rec0.final_result) |-> !o_push.push1)
        else $error("word after final result");

endmodule

// ===== rtl/brhp_out_fifo.sv =====
module brhp_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brhp_pkg::t_push    i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output brhp_pkg::t_record  o_rec
);

    localparam logic [brhp_pkg::FIFO_AW:0] DEPTH_C = (brhp_pkg::FIFO_AW + 1)'(brhp_pkg::FIFO_DEPTH);

    brhp_pkg::t_record             r_mem [brhp_pkg::FIFO_DEPTH];
    logic [brhp_pkg::FIFO_AW-1:0]  r_wp,    n_wp;
    logic [brhp_pkg::FIFO_AW-1:0]  r_rp,    n_rp;
    logic [brhp_pkg::FIFO_AW:0]    r_count, n_count;
    logic                          pop;
    logic [brhp_pkg::FIFO_AW-1:0]  wp_next;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rp];
    assign pop     = o_valid & i_ready;
    // Leave space for the two words one byte may produce.
    assign o_room  = (r_count <= DEPTH_C - 2);
    assign wp_next = r_wp + 1'b1;

    always_comb begin
        n_wp    = r_wp + {{(brhp_pkg::FIFO_AW-1){1'b0}}, i_push.push0}
                       + {{(brhp_pkg::FIFO_AW-1){1'b0}}, i_push.push1};
        n_rp    = r_rp + {{(brhp_pkg::FIFO_AW-1){1'b0}}, pop};
        n_count = r_count + {{brhp_pkg::FIFO_AW{1'b0}}, i_push.push0}
                          + {{brhp_pkg::FIFO_AW{1'b0}}, i_push.push1}
                          - {{brhp_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wp] <= i_push.rec0;
        end
        if (i_push.push1) begin
            r_mem[wp_next] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> (r_count <= DEPTH_C - 2))
        else $error("push without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count beyond depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.push0 && !pop) |=> $stable(r_count))
        else $error("fill count moved without push or pop");

endmodule

// ===== rtl/binary_result_header_parser.sv =====
// Path: a result word is written into the output queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that yields two words (header plus done,
//   or a text byte plus an error) writes both words into the queue at once.
// Output: a four-word queue; input ready while at least two entries are free.
// Reset: synchronous, active low; clears the parser, the queue and expected_version.
module binary_result_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream in
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    // configuration write: expected_version
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    // result words out
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_record_kind,
    output logic [2:0]   o_status,
    output logic [15:0]  o_code_first,
    output logic [15:0]  o_code_second,
    output logic [15:0]  o_text_length,
    output logic [15:0]  o_count_value,
    output logic [63:0]  o_rows_affected,
    output logic [63:0]  o_inserted_id,
    output logic [7:0]   o_text_byte,
    output logic         o_final_result
);

    brhp_pkg::t_push    push;
    brhp_pkg::t_record  head_rec;
    logic               room;
    logic               accept;

    // Take config writes at any time; the host must write only while idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    // Advance the parser only on an accepted byte.
    assign o_ready = room;
    assign accept  = i_valid & room;

    brhp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    // Hold finished words here until the consumer takes them.
    brhp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rec   (head_rec)
    );

    assign o_record_kind   = head_rec.record_kind;
    assign o_status        = head_rec.status;
    assign o_code_first    = head_rec.code_first;
    assign o_code_second   = head_rec.code_second;
    assign o_text_length   = head_rec.text_length;
    assign o_count_value   = head_rec.count_value;
    assign o_rows_affected = head_rec.rows_affected;
    assign o_inserted_id   = head_rec.inserted_id;
    assign o_text_byte     = head_rec.text_byte;
    assign o_final_result  = head_rec.final_result;

endmodule
